// File: src/swm_pkg.sv
// shared constants for the sliding window mode filter
// no dependencies; compiled before the interfaces and modules
package swm_pkg;

	localparam int CFG_W   = 7;
	localparam int COUNT_W = 7;

	localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(8);

endpackage

// File: src/swm_if.sv
// valid/ready channel interfaces for sample words and mode result words
// no package dependency; data widths follow SAMPLE_BITS, the count is 7 bits
interface swm_sample_if #(
	parameter int SAMPLE_BITS = 8
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface swm_mode_if #(
	parameter int SAMPLE_BITS = 8
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] mode_value;
	logic [6:0]             mode_count;

	modport source (output valid, output mode_value, output mode_count, input ready);
	modport sink   (input valid, input mode_value, input mode_count, output ready);
endinterface

// File: src/swm_ring_ram.sv
// ring memory holding the most recent samples
// one write port and two registered read ports; no package dependency
module swm_ring_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: src/swm_ctrl.sv
// sequencer: stores each sample in the ring; with a full window counts every window sample
// against the whole window through two read ports and keeps the best; uses swm_pkg
module swm_ctrl import swm_pkg::*; #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] len,
	swm_sample_if.sink       sample_ch,
	swm_mode_if.source       mode_ch
);

	localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int FILL_W = $clog2(MAX_WINDOW + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	state_t                   state_q;
	logic [PTR_W-1:0]         oldest_q;
	logic [PTR_W-1:0]         newest_q;
	logic [FILL_W-1:0]        fill_q;
	logic [CFG_W-1:0]         len_q;
	logic [PTR_W-1:0]         i_ptr_q;
	logic [PTR_W-1:0]         j_ptr_q;
	logic [COUNT_W-1:0]       i_cnt_q;
	logic [COUNT_W-1:0]       j_cnt_q;
	logic [COUNT_W-1:0]       cnt_q;
	logic                     vld_s1;
	logic [SAMPLE_BITS-1:0]   best_val_q;
	logic [COUNT_W-1:0]       best_cnt_q;
	logic                     out_valid_q;
	logic [SAMPLE_BITS-1:0]   out_value_q;
	logic [COUNT_W-1:0]       out_count_q;

	logic                     ram_we;
	logic [SAMPLE_BITS-1:0]   rdata_a;
	logic [SAMPLE_BITS-1:0]   rdata_b;
	logic [FILL_W-1:0]        fill_next;
	logic [COUNT_W-1:0]       cnt_sum;
	logic                     better;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(MAX_WINDOW - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == '0) begin
			r = PTR_W'(MAX_WINDOW - 1);
		end else begin
			r = p - PTR_W'(1);
		end
		return r;
	endfunction

	assign sample_ch.ready    = (state_q == ST_IDLE);
	assign ram_we             = sample_ch.valid && (state_q == ST_IDLE);
	assign mode_ch.valid      = out_valid_q;
	assign mode_ch.mode_value = out_value_q;
	assign mode_ch.mode_count = out_count_q;

	assign fill_next = (fill_q == FILL_W'(MAX_WINDOW)) ? fill_q : fill_q + FILL_W'(1);
	// the pending compare lands in the cycle after its address went out
	assign cnt_sum   = cnt_q + COUNT_W'(vld_s1 && (rdata_a == rdata_b));
	assign better    = (cnt_sum > best_cnt_q) ||
		((cnt_sum == best_cnt_q) && (rdata_a < best_val_q));

	swm_ring_ram #(
		.DEPTH (MAX_WINDOW),
		.WIDTH (SAMPLE_BITS),
		.AW    (PTR_W)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (oldest_q),
		.wdata   (sample_ch.sample),
		.raddr_a (i_ptr_q),
		.raddr_b (j_ptr_q),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			oldest_q    <= '0;
			newest_q    <= '0;
			fill_q      <= '0;
			len_q       <= '0;
			i_ptr_q     <= '0;
			j_ptr_q     <= '0;
			i_cnt_q     <= '0;
			j_cnt_q     <= '0;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			best_val_q  <= '0;
			best_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_count_q <= '0;
		end else begin
			vld_s1 <= (state_q == ST_RUN);
			// in ST_FIN the output register is handled by the load below
			if (out_valid_q && mode_ch.ready && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample_ch.valid) begin
						oldest_q   <= ptr_inc(oldest_q);
						newest_q   <= oldest_q;
						fill_q     <= fill_next;
						len_q      <= len;
						i_ptr_q    <= oldest_q;
						j_ptr_q    <= oldest_q;
						i_cnt_q    <= '0;
						j_cnt_q    <= '0;
						cnt_q      <= '0;
						best_val_q <= '0;
						best_cnt_q <= '0;
						if (int'(fill_next) >= int'(len)) begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					cnt_q   <= cnt_sum;
					j_ptr_q <= ptr_dec(j_ptr_q);
					j_cnt_q <= j_cnt_q + COUNT_W'(1);
					if (j_cnt_q == len_q - CFG_W'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// last compare of this candidate is in cnt_sum now
					if (better) begin
						best_cnt_q <= cnt_sum;
						best_val_q <= rdata_a;
					end
					cnt_q   <= '0;
					j_ptr_q <= newest_q;
					j_cnt_q <= '0;
					if (i_cnt_q == len_q - CFG_W'(1)) begin
						state_q <= ST_FIN;
					end else begin
						i_ptr_q <= ptr_dec(i_ptr_q);
						i_cnt_q <= i_cnt_q + COUNT_W'(1);
						state_q <= ST_RUN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || mode_ch.ready) begin
						out_valid_q <= 1'b1;
						out_value_q <= best_val_q;
						out_count_q <= best_cnt_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/sliding_window_mode_filter.sv
// a word that fills the window gives its result after a pairwise compare loop over the
// window through the two read ports of the ring memory; other words are only stored
// no new word is taken until that loop and the output load are done; a finished
// result waits in an output register while the next word is taken, and the load
// of the next result waits until the previous one has been taken
// reset sets the window length to 8 and clears the fill count and the ring pointer
module sliding_window_mode_filter import swm_pkg::*; #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	swm_sample_if.sink       sample_ch,
	swm_mode_if.source       mode_ch
);

	logic [CFG_W-1:0] window_len_q;
	logic [CFG_W-1:0] len_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= LEN_RESET;
		end else if (cfg_we) begin
			window_len_q <= cfg_wdata;
		end
	end

	// zero means one, anything past the ring depth means the whole ring
	always_comb begin
		if (window_len_q == '0) begin
			len_eff = CFG_W'(1);
		end else if (int'(window_len_q) > MAX_WINDOW) begin
			len_eff = CFG_W'(MAX_WINDOW);
		end else begin
			len_eff = window_len_q;
		end
	end

	swm_ctrl #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.len       (len_eff),
		.sample_ch (sample_ch),
		.mode_ch   (mode_ch)
	);

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_ch.valid |-> (mode_ch.mode_count != '0) &&
			(int'(mode_ch.mode_count) <= int'(len_eff)))
		else $error("mode count outside the window");

	a_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mode_ch.valid) |-> $past(!sample_ch.ready))
		else $error("result appeared without a finished scan");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_ch.valid && !mode_ch.ready) |=> (mode_ch.valid &&
			$stable(mode_ch.mode_value) && $stable(mode_ch.mode_count)))
		else $error("result word changed while stalled");
`endif

endmodule

// File: test/sliding_window_mode_filter_tb.sv
// testbench for sliding_window_mode_filter: random and directed sample words, a
// scoreboard that predicts each window mode and checks the result words in order
// depends on swm_pkg, the swm_sample_if/swm_mode_if interfaces and the filter itself
module sliding_window_mode_filter_tb import swm_pkg::*; ();

	localparam int MAX_WINDOW    = 64;
	localparam int SAMPLE_BITS   = 8;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 20;
	localparam int NUM_SEGS      = 24;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] value;
		logic [COUNT_W-1:0]     count;
	} mode_word_t;

	class mode_scoreboard;
		logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
		int unsigned            next_slot;
		int unsigned            filled;
		logic [CFG_W-1:0]       len_reg;
		mode_word_t             expected_modes [$];
		int unsigned            errors;

		function new();
			foreach (ring[i]) ring[i] = '0;
			next_slot = 0;
			filled    = 0;
			len_reg   = LEN_RESET;
			errors    = 0;
		endfunction

		function void write_len(logic [CFG_W-1:0] v);
			len_reg = v;
		endfunction

		function int unsigned pending();
			return expected_modes.size();
		endfunction

		// store the word, then take the mode over the last len words if enough arrived
		function void note_sample(logic [SAMPLE_BITS-1:0] s);
			int unsigned occurrences [2**SAMPLE_BITS];
			int unsigned win;
			int unsigned best_cnt;
			int unsigned slot;
			mode_word_t  m;
			win = len_reg;
			if (win == 0) win = 1;
			if (win > MAX_WINDOW) win = MAX_WINDOW;
			ring[next_slot] = s;
			next_slot = (next_slot + 1) % MAX_WINDOW;
			if (filled < MAX_WINDOW) filled++;
			if (filled < win) return;
			foreach (occurrences[v]) occurrences[v] = 0;
			for (int i = 0; i < win; i++) begin
				slot = (next_slot + MAX_WINDOW - 1 - i) % MAX_WINDOW;
				occurrences[ring[slot]]++;
			end
			// ascending scan with strict compare keeps the smallest value on ties
			best_cnt = 0;
			m.value  = '0;
			for (int v = 0; v < 2**SAMPLE_BITS; v++) begin
				if (occurrences[v] > best_cnt) begin
					best_cnt = occurrences[v];
					m.value  = v[SAMPLE_BITS-1:0];
				end
			end
			m.count = best_cnt[COUNT_W-1:0];
			expected_modes.push_back(m);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [SAMPLE_BITS-1:0] value, logic [COUNT_W-1:0] count);
			mode_word_t m;
			if (expected_modes.size() == 0) begin
				report($sformatf("unexpected result word value %0d count %0d", value, count));
				return;
			end
			m = expected_modes.pop_front();
			if (value !== m.value)
				report($sformatf("mode_value %0d, expected %0d", value, m.value));
			if (count !== m.count)
				report($sformatf("mode_count %0d, expected %0d", count, m.count));
		endtask
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	int unsigned      send_idle_pct;
	int unsigned      recv_stall_pct;
	mode_scoreboard   sb;

	swm_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
	swm_mode_if   #(.SAMPLE_BITS(SAMPLE_BITS)) mode_ch ();

	sliding_window_mode_filter #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample_ch (sample_ch),
		.mode_ch   (mode_ch)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		mode_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// results first, then the word taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (mode_ch.valid && mode_ch.ready)
				sb.check_result(mode_ch.mode_value, mode_ch.mode_count);
			if (sample_ch.valid && sample_ch.ready)
				sb.note_sample(sample_ch.sample);
		end
	end

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= s;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// only with nothing in flight; valid drops first so the last word is noted before pending is read
	task automatic set_window(input logic [CFG_W-1:0] v);
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_len(v);
	endtask

	initial begin
		#8_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int unsigned            len;
		int unsigned            n_items;
		int unsigned            spread;
		logic [SAMPLE_BITS-1:0] base;
		logic [SAMPLE_BITS-1:0] s;
		sb = new();
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_wdata        <= '0;
		sample_ch.valid  <= 1'b0;
		sample_ch.sample <= '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset length 8: the eighth word fills the window, 0 and 255 tie
		send_sample(8'h00); send_sample(8'hFF); send_sample(8'h55); send_sample(8'hAA);
		send_sample(8'hFF); send_sample(8'h00); send_sample(8'h01); send_sample(8'h80);
		send_sample(8'hFF);
		set_window(CFG_W'(1));
		send_sample(8'h7F); send_sample(8'h80); send_sample(8'h01);
		// zero length behaves as one
		set_window(CFG_W'(0));
		send_sample(8'hFE); send_sample(8'h00);
		set_window(CFG_W'(2));
		send_sample(8'h03); send_sample(8'h02); send_sample(8'h02);
		// above the ring size: clamps to 64, not enough words yet
		set_window(CFG_W'(127));
		send_sample(8'h10); send_sample(8'h10);
		// shorter again mid-stream: the first word after the change fills the window
		set_window(CFG_W'(20));
		send_sample(8'h10); send_sample(8'h11);

		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			case (seg)
				0:       begin len = MAX_WINDOW; n_items = 70; end
				5:       begin len = 127;        n_items = 20; end
				10:      begin len = 65;         n_items = 10; end
				15:      begin len = 33;         n_items = 30; end
				default: begin len = $urandom_range(0, 16); n_items = 83; end
			endcase
			set_window(CFG_W'(len));
			case (seg % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			// narrow alphabets give repeats and ties, the rest is full-range noise
			base   = SAMPLE_BITS'($urandom_range(255));
			spread = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(1, 4);
			for (int k = 0; k < n_items; k++) begin
				if ($urandom_range(99) < 15)
					s = SAMPLE_BITS'($urandom_range(255));
				else
					s = SAMPLE_BITS'(base + $urandom_range(spread));
				send_sample(s);
			end
		end

		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
